// ===== rtl/pdgc_pkg.sv =====
// Shared codes, constants and word types of the PD GoodCRC handshake engine.
`default_nettype none

package pdgc_pkg;

	// defaults of the top-level parameters
	localparam int MAX_PAYLOAD_DEF  = 260;
	localparam int BUFFER_BYTES_DEF = 512;

	// received packet: header plus CRC bytes
	localparam int RX_OVERHEAD = 2 + 4;
	localparam int TX_HDR_BYTES = 2;
	localparam int TX_LEN_MAX = 1023;
	localparam logic [4:0] CTRL_GOODCRC = 5'd1;

	localparam int QUEUE_DEPTH = 2;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_POWER_ROLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_ROLE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_PRIME  = 2'd2;

	// event codes
	localparam logic [2:0] OP_RX         = 3'd0;
	localparam logic [2:0] OP_TX         = 3'd1;
	localparam logic [2:0] OP_TX_DONE    = 3'd2;
	localparam logic [2:0] OP_HARD_RESET = 3'd3;
	localparam logic [2:0] OP_FETCH      = 3'd4;

	// packet kinds on the wire side
	localparam logic [2:0] PKT_SOP   = 3'd0;
	localparam logic [2:0] PKT_SOPPP = 3'd2;
	localparam logic [2:0] PKT_HARD  = 3'd4;
	localparam logic [2:0] PKT_CABLE = 3'd5;

	// stored message kinds
	localparam logic [1:0] MSG_SOP     = 2'd0;
	localparam logic [1:0] MSG_INVALID = 2'd3;

	// transmit kinds
	localparam logic [2:0] TXK_SOP   = 3'd0;
	localparam logic [2:0] TXK_HARD  = 3'd3;
	localparam logic [2:0] TXK_CABLE = 3'd4;

	// alert codes
	localparam logic [2:0] ALERT_NONE       = 3'd0;
	localparam logic [2:0] ALERT_RX_OVF     = 3'd1;
	localparam logic [2:0] ALERT_MSG_STATUS = 3'd2;
	localparam logic [2:0] ALERT_TX_SUCCESS = 3'd3;
	localparam logic [2:0] ALERT_HARD_RESET = 3'd4;

	// error codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_BAD_LEN   = 3'd1;
	localparam logic [2:0] ERR_TX_BUSY   = 3'd2;
	localparam logic [2:0] ERR_NO_MSG    = 3'd3;
	localparam logic [2:0] ERR_GCRC_DROP = 3'd4;

	// classified event as it travels from the front to the back
	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] hdr;
		logic        bad_len;
		logic        is_gcrc;
		logic [1:0]  skind;
		logic [8:0]  rx_len;
		logic [2:0]  tx_kind;
		logic        tx_crc;
		logic [9:0]  tx_total;
	} ev_t;

	// one result word
	typedef struct packed {
		logic [2:0]  alert;
		logic        start_tx;
		logic [2:0]  tx_kind;
		logic [15:0] tx_header;
		logic [9:0]  tx_total_len;
		logic        tx_crc_needed;
		logic        msg_valid;
		logic [1:0]  msg_kind;
		logic [15:0] msg_header;
		logic [8:0]  msg_length;
		logic [2:0]  error;
		logic        last;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/pdgc_front.sv =====
// Front end: accepts events and classifies them into queue words.
`default_nettype none

module pdgc_front #(
	parameter int MAX_PAYLOAD  = pdgc_pkg::MAX_PAYLOAD_DEF,
	parameter int BUFFER_BYTES = pdgc_pkg::BUFFER_BYTES_DEF
) (
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [2:0]  op,
	input  wire logic [2:0]  packet_kind,
	input  wire logic [15:0] header_word,
	input  wire logic [9:0]  pkt_bytes,
	input  wire logic        q_full,
	output      logic        q_push,
	output      pdgc_pkg::ev_t q_word
);

	localparam int RX_MAX  = MAX_PAYLOAD + pdgc_pkg::RX_OVERHEAD;
	localparam int TX_CLIP = BUFFER_BYTES - 2;

	logic        op_known;
	logic [10:0] tx_len;
	logic [10:0] tx_sum;

	assign in_stall = q_full;

	// ops above fetch are taken and dropped
	always_comb begin
		case (op) inside
			[pdgc_pkg::OP_RX:pdgc_pkg::OP_FETCH]: op_known = 1'b1;
			default: op_known = 1'b0;
		endcase
	end

	assign q_push = in_valid && !q_full && op_known;

	assign tx_len = ({1'b0, pkt_bytes} > 11'(TX_CLIP)) ? 11'(TX_CLIP) : {1'b0, pkt_bytes};
	assign tx_sum = tx_len + 11'(pdgc_pkg::TX_HDR_BYTES);

	always_comb begin
		q_word.op      = op;
		q_word.hdr     = header_word;
		q_word.bad_len = (pkt_bytes < 10'(pdgc_pkg::RX_OVERHEAD)) ||
			({1'b0, pkt_bytes} > 11'(RX_MAX));
		q_word.is_gcrc = (header_word[15:12] == 4'd0) &&
			(header_word[4:0] == pdgc_pkg::CTRL_GOODCRC);
		q_word.skind   = (packet_kind <= pdgc_pkg::PKT_SOPPP) ? packet_kind[1:0]
			: pdgc_pkg::MSG_INVALID;
		q_word.rx_len  = 9'(pkt_bytes - 10'(pdgc_pkg::RX_OVERHEAD));
		q_word.tx_total = (tx_sum > 11'(pdgc_pkg::TX_LEN_MAX)) ? 10'(pdgc_pkg::TX_LEN_MAX)
			: tx_sum[9:0];
		case (packet_kind) inside
			[pdgc_pkg::PKT_SOP:pdgc_pkg::PKT_SOPPP]: begin
				q_word.tx_kind = packet_kind;
				q_word.tx_crc  = 1'b1;
			end
			pdgc_pkg::PKT_HARD: begin
				q_word.tx_kind = pdgc_pkg::TXK_HARD;
				q_word.tx_crc  = 1'b0;
			end
			pdgc_pkg::PKT_CABLE: begin
				q_word.tx_kind = pdgc_pkg::TXK_CABLE;
				q_word.tx_crc  = 1'b0;
			end
			default: begin
				q_word.tx_kind = pdgc_pkg::TXK_SOP;
				q_word.tx_crc  = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/pdgc_queue.sv =====
// Short event queue between the classifying front and the executing back.
`default_nettype none

module pdgc_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire pdgc_pkg::ev_t push_word,
	input  wire logic          pop,
	output      logic          full,
	output      logic          nonempty,
	output      pdgc_pkg::ev_t head
);

	localparam int DEPTH = pdgc_pkg::QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	pdgc_pkg::ev_t    mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (cnt_q == CW'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = mem_q[rd_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pdgc_back.sv =====
// Back end: protocol state, config registers, result expansion and output register.
`default_nettype none

module pdgc_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_valid,
	output      logic          cfg_ready,
	input  wire logic [pdgc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic          cfg_data,
	input  wire logic          q_nonempty,
	input  wire pdgc_pkg::ev_t q_head,
	output      logic          q_pop,
	input  wire logic          out_stall,
	output      logic          out_valid,
	output      pdgc_pkg::res_t out_word
);

	localparam int NSLOT = 3;

	logic power_role_q, data_role_q, ack_prime_q;
	logic tx_busy_q, tx_pending_q, sending_gcrc_q, expect_crc_q, rx_held_q, msg_ready_q;
	logic [1:0]  stored_kind_q;
	logic [15:0] stored_header_q;
	logic [8:0]  stored_length_q;

	logic tx_busy_d, tx_pending_d, sending_gcrc_d, expect_crc_d, rx_held_d, msg_ready_d;
	logic [1:0]  stored_kind_d;
	logic [15:0] stored_header_d;
	logic [8:0]  stored_length_d;

	pdgc_pkg::res_t slot_q [NSLOT];
	pdgc_pkg::res_t slot_d [NSLOT];
	logic [1:0] cnt_q, idx_q, cnt_d;

	pdgc_pkg::res_t out_q;
	logic           out_valid_q;
	logic           out_load;
	logic           draining;
	logic           ack_needed;
	logic [15:0]    gcrc_hdr;
	logic           is_sop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_role_q <= 1'b0;
			data_role_q  <= 1'b0;
			ack_prime_q  <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				pdgc_pkg::CFG_POWER_ROLE: power_role_q <= cfg_data;
				pdgc_pkg::CFG_DATA_ROLE:  data_role_q  <= cfg_data;
				pdgc_pkg::CFG_ACK_PRIME:  ack_prime_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// output register takes a word when empty or when its word leaves
	assign out_load = !out_valid_q || !out_stall;
	assign draining = (idx_q != cnt_q);
	assign q_pop    = q_nonempty &&
		((idx_q == cnt_q) || ((idx_q + 2'd1 == cnt_q) && out_load));

	assign is_sop     = (q_head.skind == pdgc_pkg::MSG_SOP);
	assign ack_needed = !q_head.is_gcrc && (q_head.skind != pdgc_pkg::MSG_INVALID) &&
		(is_sop || ack_prime_q);
	// roles only go into a GoodCRC for SOP
	assign gcrc_hdr   = {4'd0, q_head.hdr[11:9], is_sop & power_role_q, q_head.hdr[7:6],
		is_sop & data_role_q, pdgc_pkg::CTRL_GOODCRC};

	always_comb begin
		tx_busy_d       = tx_busy_q;
		tx_pending_d    = tx_pending_q;
		sending_gcrc_d  = sending_gcrc_q;
		expect_crc_d    = expect_crc_q;
		rx_held_d       = rx_held_q;
		msg_ready_d     = msg_ready_q;
		stored_kind_d   = stored_kind_q;
		stored_header_d = stored_header_q;
		stored_length_d = stored_length_q;
		cnt_d = 2'd0;
		for (int i = 0; i < NSLOT; i++) begin
			slot_d[i] = '0;
		end
		case (q_head.op)
			pdgc_pkg::OP_RX: begin
				if (q_head.bad_len) begin
					slot_d[0].error = pdgc_pkg::ERR_BAD_LEN;
					cnt_d = 2'd1;
				end else if (rx_held_q) begin
					slot_d[0].alert = pdgc_pkg::ALERT_RX_OVF;
					cnt_d = 2'd1;
				end else begin
					// unfetched message gets replaced
					if (msg_ready_q) begin
						slot_d[cnt_d].alert = pdgc_pkg::ALERT_RX_OVF;
						cnt_d = cnt_d + 2'd1;
					end
					stored_kind_d   = q_head.skind;
					stored_header_d = q_head.hdr;
					stored_length_d = q_head.rx_len;
					if (ack_needed) begin
						if (tx_busy_q) begin
							// no GoodCRC possible: drop the message
							msg_ready_d = 1'b0;
							slot_d[cnt_d].error = pdgc_pkg::ERR_GCRC_DROP;
							cnt_d = cnt_d + 2'd1;
						end else begin
							tx_busy_d      = 1'b1;
							tx_pending_d   = 1'b1;
							sending_gcrc_d = 1'b1;
							expect_crc_d   = 1'b1;
							rx_held_d      = 1'b1;
							slot_d[cnt_d].start_tx      = 1'b1;
							slot_d[cnt_d].tx_kind       = {1'b0, q_head.skind};
							slot_d[cnt_d].tx_header     = gcrc_hdr;
							slot_d[cnt_d].tx_total_len  = 10'(pdgc_pkg::TX_HDR_BYTES);
							slot_d[cnt_d].tx_crc_needed = 1'b1;
							cnt_d = cnt_d + 2'd1;
						end
					end else begin
						if (tx_pending_q && q_head.is_gcrc) begin
							tx_pending_d = 1'b0;
							tx_busy_d    = 1'b0;
							slot_d[cnt_d].alert = pdgc_pkg::ALERT_TX_SUCCESS;
							cnt_d = cnt_d + 2'd1;
						end
						msg_ready_d = 1'b1;
						slot_d[cnt_d].alert = pdgc_pkg::ALERT_MSG_STATUS;
						cnt_d = cnt_d + 2'd1;
					end
				end
			end
			pdgc_pkg::OP_TX: begin
				cnt_d = 2'd1;
				if (tx_busy_q) begin
					slot_d[0].error = pdgc_pkg::ERR_TX_BUSY;
				end else begin
					tx_busy_d      = 1'b1;
					tx_pending_d   = 1'b1;
					sending_gcrc_d = 1'b0;
					expect_crc_d   = q_head.tx_crc;
					slot_d[0].start_tx      = 1'b1;
					slot_d[0].tx_kind       = q_head.tx_kind;
					slot_d[0].tx_header     = q_head.hdr;
					slot_d[0].tx_total_len  = q_head.tx_total;
					slot_d[0].tx_crc_needed = q_head.tx_crc;
				end
			end
			pdgc_pkg::OP_TX_DONE: begin
				cnt_d = 2'd1;
				slot_d[0].alert = pdgc_pkg::ALERT_NONE;
				if (tx_busy_q) begin
					if (sending_gcrc_q) begin
						// GoodCRC out: release the held message
						sending_gcrc_d = 1'b0;
						tx_pending_d   = 1'b0;
						tx_busy_d      = 1'b0;
						msg_ready_d    = 1'b1;
						rx_held_d      = 1'b0;
						slot_d[0].alert = pdgc_pkg::ALERT_MSG_STATUS;
					end else if (!expect_crc_q) begin
						tx_pending_d = 1'b0;
						tx_busy_d    = 1'b0;
						slot_d[0].alert = pdgc_pkg::ALERT_TX_SUCCESS;
					end
				end
			end
			pdgc_pkg::OP_HARD_RESET: begin
				cnt_d = 2'd1;
				slot_d[0].alert = pdgc_pkg::ALERT_HARD_RESET;
			end
			pdgc_pkg::OP_FETCH: begin
				cnt_d = 2'd1;
				if (rx_held_q || !msg_ready_q) begin
					slot_d[0].error = pdgc_pkg::ERR_NO_MSG;
				end else begin
					msg_ready_d = 1'b0;
					slot_d[0].msg_valid  = 1'b1;
					slot_d[0].msg_kind   = stored_kind_q;
					slot_d[0].msg_header = stored_header_q;
					slot_d[0].msg_length = stored_length_q;
				end
			end
			default: cnt_d = 2'd0;
		endcase
		if (cnt_d != 2'd0) begin
			slot_d[cnt_d - 2'd1].last = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			for (int i = 0; i < NSLOT; i++) begin
				slot_q[i] <= slot_d[i];
			end
		end
		if (out_load && draining) begin
			out_q <= slot_q[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_busy_q       <= 1'b0;
			tx_pending_q    <= 1'b0;
			sending_gcrc_q  <= 1'b0;
			expect_crc_q    <= 1'b0;
			rx_held_q       <= 1'b0;
			msg_ready_q     <= 1'b0;
			stored_kind_q   <= '0;
			stored_header_q <= '0;
			stored_length_q <= '0;
			cnt_q           <= 2'd0;
			idx_q           <= 2'd0;
			out_valid_q     <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= draining;
			end
			if (q_pop) begin
				tx_busy_q       <= tx_busy_d;
				tx_pending_q    <= tx_pending_d;
				sending_gcrc_q  <= sending_gcrc_d;
				expect_crc_q    <= expect_crc_d;
				rx_held_q       <= rx_held_d;
				msg_ready_q     <= msg_ready_d;
				stored_kind_q   <= stored_kind_d;
				stored_header_q <= stored_header_d;
				stored_length_q <= stored_length_d;
				cnt_q           <= cnt_d;
				idx_q           <= 2'd0;
			end else if (out_load && draining) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= cnt_q)
		else $error("result index ran past result count");

	a_gcrc_holds: assert property (@(posedge clk) disable iff (!arst_n)
		sending_gcrc_q |-> (tx_busy_q && rx_held_q))
		else $error("GoodCRC in flight without busy transmitter and held message");

	a_pop_gives_words: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (cnt_q != 2'd0))
		else $error("event popped without producing a result");

	a_pop_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (!draining || (idx_q + 2'd1 == cnt_q && out_load)))
		else $error("event popped over undelivered results");

endmodule

`default_nettype wire

// ===== rtl/pd_goodcrc_handshake_engine_top.sv =====
// Top level of the PD GoodCRC handshake engine.
// Input channel: in_valid/in_stall carry one event word (op, packet_kind,
// header_word, pkt_bytes); a word is taken when in_valid is high and
// in_stall low. Events classify in the front and wait in a two-entry queue.
// Output channel: out_valid/out_stall carry result words; each event gives
// one to three words, the final one flagged by last. Op codes above fetch
// are taken and give no words.
// The first word of an event passes through the queue, the result slots and
// the output register; further words of the same event follow one per cycle
// while out_stall is low, as do the words of following events, so one event
// a cycle for events with a single word, set by the single output register.
// Config: cfg_valid/cfg_ready with cfg_index and cfg_data, always ready;
// write only while no event is in flight.
// Reset clears all protocol state and config to zero and empties the queue.
// A stalled output holds its word; the queue then fills and in_stall rises.
`default_nettype none

module pd_goodcrc_handshake_engine_top #(
	parameter int MAX_PAYLOAD  = pdgc_pkg::MAX_PAYLOAD_DEF,
	parameter int BUFFER_BYTES = pdgc_pkg::BUFFER_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [pdgc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic        cfg_data,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [2:0]  op,
	input  wire logic [2:0]  packet_kind,
	input  wire logic [15:0] header_word,
	input  wire logic [9:0]  pkt_bytes,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [2:0]  alert,
	output      logic        start_tx,
	output      logic [2:0]  tx_kind,
	output      logic [15:0] tx_header,
	output      logic [9:0]  tx_total_len,
	output      logic        tx_crc_needed,
	output      logic        msg_valid,
	output      logic [1:0]  msg_kind,
	output      logic [15:0] msg_header,
	output      logic [8:0]  msg_length,
	output      logic [2:0]  error,
	output      logic        last
);

	pdgc_pkg::ev_t  push_word;
	pdgc_pkg::ev_t  head;
	pdgc_pkg::res_t res;
	logic push, pop, full, nonempty;

	pdgc_front #(
		.MAX_PAYLOAD  (MAX_PAYLOAD),
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_front (
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.packet_kind (packet_kind),
		.header_word (header_word),
		.pkt_bytes   (pkt_bytes),
		.q_full      (full),
		.q_push      (push),
		.q_word      (push_word)
	);

	pdgc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.full      (full),
		.nonempty  (nonempty),
		.head      (head)
	);

	pdgc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_nonempty (nonempty),
		.q_head     (head),
		.q_pop      (pop),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.out_word   (res)
	);

	assign alert         = res.alert;
	assign start_tx      = res.start_tx;
	assign tx_kind       = res.tx_kind;
	assign tx_header     = res.tx_header;
	assign tx_total_len  = res.tx_total_len;
	assign tx_crc_needed = res.tx_crc_needed;
	assign msg_valid     = res.msg_valid;
	assign msg_kind      = res.msg_kind;
	assign msg_header    = res.msg_header;
	assign msg_length    = res.msg_length;
	assign error         = res.error;
	assign last          = res.last;

endmodule

`default_nettype wire
